// ===== rtl/core/sem_pkg.sv =====
// Shared widths and the root-cell state type for the Sobel edge magnitude unit.
// Used by every module under rtl/core; depends on nothing.
package sem_pkg;

  localparam int PIX_W    = 8;                  // pixel width
  localparam int SUM_W    = 10;                 // one weighted column sum, at most 1020
  localparam int SQ_W     = 2 * SUM_W;          // one squared gradient
  localparam int RAD_W    = SQ_W + 2;           // sum of squares, even width
  localparam int ROOT_W   = RAD_W / 2;          // root bits, one per cell
  localparam int REM_W    = ROOT_W + 3;         // partial remainder with headroom
  localparam int ROOT_STEPS = ROOT_W;           // cells in the root chain
  localparam int MAG_W    = 8;                  // output magnitude width
  localparam logic [MAG_W-1:0] MAG_MAX = 8'hFF;

  // State handed from one root cell to the next.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } root_state_t;

endpackage

// ===== rtl/core/sem_front.sv =====
// Front end: Sobel gradients, absolute values, squares and their sum.
// Three pipeline stages with valid/ready flow; depends on sem_pkg.
module sem_front
  import sem_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [PIX_W-1:0] pix_top_left,
  input  logic [PIX_W-1:0] pix_top_mid,
  input  logic [PIX_W-1:0] pix_top_right,
  input  logic [PIX_W-1:0] pix_mid_left,
  input  logic [PIX_W-1:0] pix_mid_right,
  input  logic [PIX_W-1:0] pix_bot_left,
  input  logic [PIX_W-1:0] pix_bot_mid,
  input  logic [PIX_W-1:0] pix_bot_right,
  output logic             dn_valid,
  input  logic             dn_ready,
  output root_state_t      dn_data
);

  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3;
  logic [SUM_W-1:0]  ax, ay;
  logic [SQ_W-1:0]   sqx, sqy;
  logic [RAD_W-1:0]  energy;

  logic [SUM_W-1:0]  xpos, xneg, ypos, yneg;

  // Weighted column and row sums, each below 1024
  assign xpos = SUM_W'(pix_top_right) + {1'b0, pix_mid_right, 1'b0} + SUM_W'(pix_bot_right);
  assign xneg = SUM_W'(pix_top_left) + {1'b0, pix_mid_left, 1'b0} + SUM_W'(pix_bot_left);
  assign ypos = SUM_W'(pix_bot_left) + {1'b0, pix_bot_mid, 1'b0} + SUM_W'(pix_bot_right);
  assign yneg = SUM_W'(pix_top_left) + {1'b0, pix_top_mid, 1'b0} + SUM_W'(pix_top_right);

  // Each stage advances when it is empty or its successor takes the beat
  assign rdy3     = !v3 || dn_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Absolute gradients, squares, then their sum
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      ax <= (xpos >= xneg) ? xpos - xneg : xneg - xpos;
      ay <= (ypos >= yneg) ? ypos - yneg : yneg - ypos;
    end
    if (rdy2 && v1) begin
      sqx <= SQ_W'(ax) * SQ_W'(ax);
      sqy <= SQ_W'(ay) * SQ_W'(ay);
    end
    if (rdy3 && v2) begin
      energy <= RAD_W'(sqx) + RAD_W'(sqy);
    end
  end

  assign dn_valid     = v3;
  assign dn_data.rem  = '0;
  assign dn_data.root = '0;
  assign dn_data.rad  = energy;

endmodule

// ===== rtl/core/sem_root_cell.sv =====
// One restoring square-root cell: settles one root bit from two radicand bits.
// Registered stage with valid/ready flow; depends on sem_pkg.
module sem_root_cell
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  root_state_t up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output root_state_t dn_data
);

  logic              valid;
  root_state_t       state;
  logic [REM_W-1:0]  rem_shift, trial;
  logic              fits;

  // Bring down the next radicand pair and test the trial divisor
  assign rem_shift = {up_data.rem[REM_W-3:0], up_data.rad[RAD_W-1 -: 2]};
  assign trial     = REM_W'({up_data.root, 2'b01});
  assign fits      = trial <= rem_shift;

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Restore or keep the remainder, append the root bit, drop the used pair
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state.rem  <= fits ? rem_shift - trial : rem_shift;
      state.root <= {up_data.root[ROOT_W-2:0], fits};
      state.rad  <= {up_data.rad[RAD_W-3:0], 2'b00};
    end
  end

  assign dn_valid = valid;
  assign dn_data  = state;

endmodule

// ===== rtl/core/sobel_edge_magnitude_unit.sv =====
// Top level of the Sobel edge magnitude unit: front end, root cell chain, output register.
// Depends on sem_pkg, sem_front and sem_root_cell.
//
// Usage:
//   The input channel takes one 3x3 pixel window per beat (in_valid high, in_stall low
//   at a rising clk edge). The output channel gives one edge_magnitude per window, in
//   order, on out_valid; the receiver holds it with out_stall.
//   edge_magnitude = min(255, floor(sqrt(gx^2 + gy^2))) with the standard Sobel kernels.
//   From accepted window to out_valid a window passes three front-end stages
//   (gradients, squares, sum), eleven root cells (one root bit each) and the output
//   register. Throughput is one window per cycle while out_stall is low.
//   Every stage holds its own valid bit, so bubbles close up: while out_stall is high
//   the chain keeps accepting windows until every stage is full, and in_stall rises
//   only then. A stalled result holds steady on the output.
//   rst (synchronous, active high) empties the pipeline; no other state is kept.
module sobel_edge_magnitude_unit
  import sem_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] pix_top_left,
  input  logic [PIX_W-1:0] pix_top_mid,
  input  logic [PIX_W-1:0] pix_top_right,
  input  logic [PIX_W-1:0] pix_mid_left,
  input  logic [PIX_W-1:0] pix_mid_mid,
  input  logic [PIX_W-1:0] pix_mid_right,
  input  logic [PIX_W-1:0] pix_bot_left,
  input  logic [PIX_W-1:0] pix_bot_mid,
  input  logic [PIX_W-1:0] pix_bot_right,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [MAG_W-1:0] edge_magnitude
);

  logic             front_ready;
  logic             chain_valid [ROOT_STEPS+1];
  logic             chain_ready [ROOT_STEPS+1];
  root_state_t      chain_data  [ROOT_STEPS+1];
  logic             out_ready;
  logic             mag_valid;
  logic [MAG_W-1:0] mag;
  logic [ROOT_W-1:0] root_final;
  logic             centre_unused;

  // The centre pixel carries zero weight in both kernels
  assign centre_unused = |pix_mid_mid;

  assign in_stall = !front_ready;

  sem_front u_front (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (in_valid),
    .up_ready      (front_ready),
    .pix_top_left  (pix_top_left),
    .pix_top_mid   (pix_top_mid),
    .pix_top_right (pix_top_right),
    .pix_mid_left  (pix_mid_left),
    .pix_mid_right (pix_mid_right),
    .pix_bot_left  (pix_bot_left),
    .pix_bot_mid   (pix_bot_mid),
    .pix_bot_right (pix_bot_right),
    .dn_valid      (chain_valid[0]),
    .dn_ready      (chain_ready[0]),
    .dn_data       (chain_data[0])
  );

  // Root chain: one cell per root bit, most significant first
  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    sem_root_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  // Saturate the root into the output register
  assign root_final           = chain_data[ROOT_STEPS].root;
  assign out_ready            = !mag_valid || !out_stall;
  assign chain_ready[ROOT_STEPS] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (out_ready) begin
      mag_valid <= chain_valid[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && chain_valid[ROOT_STEPS]) begin
      mag <= (|root_final[ROOT_W-1:MAG_W]) ? MAG_MAX : root_final[MAG_W-1:0];
    end
  end

  assign out_valid      = mag_valid;
  assign edge_magnitude = centre_unused ? mag : mag;

endmodule
